FILE: rtl/core/tlac_pkg.sv
// Package: item types, frame, request and role codes for the token link ARQ controller.
package tlac_pkg;

    localparam int BIND_WAIT_LG = 4;
    localparam logic [15:0] BIND_WAIT = 16'(1 << BIND_WAIT_LG);
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    localparam logic [7:0]  RST_MAX_ATTEMPTS  = 8'd5;
    localparam logic [15:0] RST_LISTEN_TICKS  = 16'd100;
    localparam logic [15:0] RST_LOSS_TICKS    = 16'd1000;
    localparam logic [7:0]  RST_BIND_ATTEMPTS = 8'd10;

    typedef enum logic [1:0] {
        CFG_MAX_ATTEMPTS  = 2'd0,
        CFG_LISTEN_TICKS  = 2'd1,
        CFG_LOSS_TICKS    = 2'd2,
        CFG_BIND_ATTEMPTS = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_FRAME = 3'd1,
        CMD_BIND  = 3'd2,
        CMD_SEND  = 3'd3,
        CMD_TOKEN = 3'd4,
        CMD_CLOSE = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        F_BIND         = 3'd0,
        F_ACK          = 3'd1,
        F_DATA0        = 3'd2,
        F_DATA1        = 3'd3,
        F_TOKENPASS    = 3'd4,
        F_TOKENPASSACK = 3'd5,
        F_CLOSE        = 3'd6,
        F_ALIVE        = 3'd7
    } t_frame;

    typedef enum logic [2:0] {
        P_NONE     = 3'd0,
        P_BIND     = 3'd1,
        P_DATA     = 3'd2,
        P_TOKEN    = 3'd3,
        P_CLOSE    = 3'd4,
        P_ALIVE    = 3'd5,
        P_TOKENACK = 3'd6
    } t_pend;

    typedef enum logic [1:0] {
        ROLE_DOWN      = 2'd0,
        ROLE_PRIMARY   = 2'd1,
        ROLE_SECONDARY = 2'd2
    } t_role;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  rx_type;
        logic [15:0] payload_ref;
    } t_in_item;

    typedef struct packed {
        logic        tx_valid;
        logic [2:0]  tx_type;
        logic [15:0] tx_payload_ref;
        logic        deliver_valid;
        logic [15:0] deliver_ref;
        logic        token_event;
        logic        close_event;
        logic [1:0]  link_state;
        logic        done_valid;
        logic        done_ok;
        logic        busy_res;
    } t_out_item;

endpackage

FILE: rtl/core/token_link_arq_controller.sv
// Token link ARQ controller: alternating-bit stop-and-wait link control for a half-duplex link.
//
// Usage: each request on the input channel (i_in_valid / o_in_stall, payload i_in_item)
// is a timer tick, a received frame or an application request (bind, send, pass token,
// close). Every request produces exactly one result on the output channel
// (o_out_valid / i_out_stall, payload o_out_item): the frame to transmit, data delivery,
// token and close events, the link role and request completion.
// A request is held in the input register, then the whole state update runs in one pass
// of logic into the result register. Throughput is one request per cycle while the result
// is not stalled; the input register and the link state advance together, so back-to-back
// requests see each other's state updates.
// When the receiver stalls, the result is held and the input register fills; once both
// are full o_in_stall rises until the result is taken.
// Reset (i_rst_n low at a clock edge) drops the link, clears all timers and the pending
// transmission, reloads the configuration defaults and seeds the backoff LFSR.
// Configuration registers are written with i_cfg_we, i_cfg_idx and i_cfg_data; the user must
// write them only while no request is in flight, as the block does not enforce this.
module token_link_arq_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tlac_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tlac_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data
);
    import tlac_pkg::*;

    // Configuration
    logic [7:0]  r_max_att;
    logic [15:0] r_listen;
    logic [15:0] r_loss;
    logic [7:0]  r_bind_att;

    // Pipeline registers
    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out, n_out;
    logic      adv;

    // Link state
    t_role       r_role, n_role;
    logic        r_send_seq, n_send_seq;
    logic        r_recv_seq, n_recv_seq;
    t_pend       r_kind, n_kind;
    logic [15:0] r_pref, n_pref;
    logic [7:0]  r_att, n_att;
    logic [15:0] r_wait, n_wait;
    logic [15:0] r_idle, n_idle;
    logic [15:0] r_lfsr, n_lfsr;

    // Decision flags within one pass
    logic       s_fail;
    logic       s_fin;
    logic       s_fin_ok;
    logic       s_tx;
    logic [7:0] s_limit;
    t_pend      s_fin_kind;

    assign adv         = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !adv;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    always_comb begin
        n_role     = r_role;
        n_send_seq = r_send_seq;
        n_recv_seq = r_recv_seq;
        n_kind     = r_kind;
        n_pref     = r_pref;
        n_att      = r_att;
        n_wait     = r_wait;
        n_idle     = r_idle;
        n_lfsr     = r_lfsr;
        n_out      = '0;
        s_fail     = 1'b0;
        s_fin      = 1'b0;
        s_fin_ok   = 1'b0;
        s_tx       = 1'b0;
        s_fin_kind = r_kind;
        s_limit    = (r_kind == P_BIND) ? r_bind_att : r_max_att;

        case (t_cmd'(r_in.cmd))
            CMD_TICK: begin
                if (r_idle != 16'hFFFF) begin
                    n_idle = r_idle + 16'd1;
                end
                if (r_kind != P_NONE) begin
                    if (r_wait <= 16'd1) begin
                        s_fail = 1'b1;
                    end else begin
                        n_wait = r_wait - 16'd1;
                    end
                end else if (r_role == ROLE_SECONDARY) begin
                    if (n_idle > r_loss) begin
                        n_role = ROLE_DOWN;
                        n_out.close_event = 1'b1;
                    end
                end else if (r_role == ROLE_PRIMARY) begin
                    // Keep-alive after half the loss time without traffic.
                    if (n_idle > {1'b0, r_loss[15:1]}) begin
                        n_kind = P_ALIVE;
                        n_pref = '0;
                        n_att  = 8'd1;
                        s_tx   = 1'b1;
                    end
                end
            end
            CMD_FRAME: begin
                n_idle = '0;
                if (r_kind == P_BIND) begin
                    if (r_in.rx_type == F_ACK) begin
                        n_role = ROLE_PRIMARY;
                        s_fin = 1'b1;
                        s_fin_ok = 1'b1;
                    end else if (r_in.rx_type == F_BIND) begin
                        n_out.tx_valid = 1'b1;
                        n_out.tx_type  = F_ACK;
                        n_role = ROLE_SECONDARY;
                        s_fin = 1'b1;
                        s_fin_ok = 1'b1;
                    end else begin
                        s_fail = 1'b1;
                    end
                end else if (r_kind == P_TOKEN) begin
                    if (r_in.rx_type == F_TOKENPASSACK) begin
                        s_fin = 1'b1;
                        s_fin_ok = 1'b1;
                    end else begin
                        s_fail = 1'b1;
                    end
                end else if (r_kind != P_NONE) begin
                    if (r_in.rx_type == F_ACK) begin
                        s_fin = 1'b1;
                        s_fin_ok = 1'b1;
                    end else begin
                        s_fail = 1'b1;
                    end
                end else if (r_role == ROLE_SECONDARY) begin
                    case (t_frame'(r_in.rx_type))
                        F_DATA0, F_DATA1: begin
                            // Duplicates are acknowledged but not delivered.
                            if (r_in.rx_type[0] == r_recv_seq) begin
                                n_out.deliver_valid = 1'b1;
                                n_out.deliver_ref   = r_in.payload_ref;
                                n_recv_seq = !r_recv_seq;
                            end
                            n_out.tx_valid = 1'b1;
                            n_out.tx_type  = F_ACK;
                        end
                        F_TOKENPASS: begin
                            n_role = ROLE_PRIMARY;
                            n_kind = P_TOKENACK;
                            n_pref = '0;
                            n_att  = 8'd1;
                            s_tx   = 1'b1;
                        end
                        F_CLOSE: begin
                            n_out.tx_valid = 1'b1;
                            n_out.tx_type  = F_ACK;
                            n_role = ROLE_DOWN;
                            n_kind = P_NONE;
                            n_out.close_event = 1'b1;
                        end
                        F_ACK: begin
                        end
                        default: begin
                            n_out.tx_valid = 1'b1;
                            n_out.tx_type  = F_ACK;
                        end
                    endcase
                end
            end
            CMD_BIND, CMD_SEND, CMD_TOKEN, CMD_CLOSE: begin
                if (r_kind != P_NONE) begin
                    n_out.done_valid = 1'b1;
                end else if (r_in.cmd == CMD_BIND) begin
                    if (r_role != ROLE_DOWN) begin
                        n_out.done_valid = 1'b1;
                    end else begin
                        n_send_seq = 1'b0;
                        n_recv_seq = 1'b0;
                        n_kind = P_BIND;
                        n_pref = '0;
                        n_att  = 8'd1;
                        s_tx   = 1'b1;
                    end
                end else if (r_in.cmd == CMD_SEND || r_in.cmd == CMD_TOKEN) begin
                    if (r_role != ROLE_PRIMARY) begin
                        n_out.done_valid = 1'b1;
                    end else begin
                        n_kind = (r_in.cmd == CMD_SEND) ? P_DATA : P_TOKEN;
                        n_pref = (r_in.cmd == CMD_SEND) ? r_in.payload_ref : '0;
                        n_att  = 8'd1;
                        s_tx   = 1'b1;
                    end
                end else begin
                    if (r_role == ROLE_PRIMARY) begin
                        n_kind = P_CLOSE;
                        n_pref = '0;
                        n_att  = 8'd1;
                        s_tx   = 1'b1;
                    end else begin
                        n_role = ROLE_DOWN;
                        n_kind = P_NONE;
                        n_out.close_event = 1'b1;
                        n_out.done_valid  = 1'b1;
                        n_out.done_ok     = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        // A timeout or a wrong answer either repeats the frame or gives up.
        if (s_fail) begin
            if (r_att < s_limit) begin
                n_att = r_att + 8'd1;
                s_tx  = 1'b1;
            end else begin
                s_fin    = 1'b1;
                s_fin_ok = 1'b0;
            end
        end

        if (s_fin) begin
            n_kind = P_NONE;
            case (s_fin_kind)
                P_BIND: begin
                    n_out.done_valid = 1'b1;
                    n_out.done_ok    = s_fin_ok;
                end
                P_DATA: begin
                    if (s_fin_ok) begin
                        n_send_seq = !r_send_seq;
                    end else begin
                        n_role = ROLE_DOWN;
                        n_out.close_event = 1'b1;
                    end
                    n_out.done_valid = 1'b1;
                    n_out.done_ok    = s_fin_ok;
                end
                P_TOKEN: begin
                    if (s_fin_ok) begin
                        n_role = ROLE_SECONDARY;
                        n_out.tx_valid = 1'b1;
                        n_out.tx_type  = F_ACK;
                    end
                    n_out.done_valid = 1'b1;
                    n_out.done_ok    = s_fin_ok;
                end
                P_CLOSE: begin
                    n_role = ROLE_DOWN;
                    n_out.close_event = 1'b1;
                    n_out.done_valid  = 1'b1;
                    n_out.done_ok     = s_fin_ok;
                end
                P_ALIVE: begin
                    if (!s_fin_ok) begin
                        n_role = ROLE_DOWN;
                        n_out.close_event = 1'b1;
                    end
                end
                default: begin
                    n_out.token_event = 1'b1;
                end
            endcase
        end

        if (s_tx) begin
            n_wait = r_listen;
            n_out.tx_valid = 1'b1;
            case (n_kind)
                P_BIND: begin
                    n_lfsr = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_MASK : 16'h0000);
                    n_wait = BIND_WAIT + {{(16 - BIND_WAIT_LG){1'b0}}, n_lfsr[BIND_WAIT_LG-1:0]};
                    n_out.tx_type = F_BIND;
                end
                P_DATA: begin
                    n_out.tx_type = n_send_seq ? F_DATA1 : F_DATA0;
                    n_out.tx_payload_ref = n_pref;
                end
                P_TOKEN: n_out.tx_type = F_TOKENPASS;
                P_CLOSE: n_out.tx_type = F_CLOSE;
                P_ALIVE: n_out.tx_type = F_ALIVE;
                default: n_out.tx_type = F_TOKENPASSACK;
            endcase
        end

        if (n_out.tx_valid) begin
            n_idle = '0;
        end

        n_out.link_state = n_role;
        n_out.busy_res   = (n_kind != P_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_att  <= RST_MAX_ATTEMPTS;
            r_listen   <= RST_LISTEN_TICKS;
            r_loss     <= RST_LOSS_TICKS;
            r_bind_att <= RST_BIND_ATTEMPTS;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_ATTEMPTS:  r_max_att  <= i_cfg_data[7:0];
                CFG_LISTEN_TICKS:  r_listen   <= i_cfg_data;
                CFG_LOSS_TICKS:    r_loss     <= i_cfg_data;
                CFG_BIND_ATTEMPTS: r_bind_att <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_role     <= ROLE_DOWN;
            r_send_seq <= 1'b0;
            r_recv_seq <= 1'b0;
            r_kind     <= P_NONE;
            r_pref     <= '0;
            r_att      <= '0;
            r_wait     <= '0;
            r_idle     <= '0;
            r_lfsr     <= LFSR_SEED;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld  <= 1'b1;
                r_role     <= n_role;
                r_send_seq <= n_send_seq;
                r_recv_seq <= n_recv_seq;
                r_kind     <= n_kind;
                r_pref     <= n_pref;
                r_att      <= n_att;
                r_wait     <= n_wait;
                r_idle     <= n_idle;
                r_lfsr     <= n_lfsr;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    // A down link can only be waiting on its own bind.
    a_down_only_bind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_role == ROLE_DOWN && r_kind != P_NONE) |-> (r_kind == P_BIND))
        else $error("pending frame other than BIND while link is down");

    // A pending frame has been sent at least once.
    a_pending_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kind != P_NONE) |-> (r_att != 8'd0))
        else $error("pending frame with zero attempt count");

    // Link state only moves when a request passes into the result register.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |=> ($stable(r_role) && $stable(r_kind) && $stable(r_idle)))
        else $error("link state changed while the result was stalled");

endmodule
